// ----- hw/rtl/segtree_pkg.sv -----
package segtree_pkg;

  localparam int VAL_W     = 64;
  localparam int POS_W     = 10;
  localparam int END_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_LEAVES = 1024;

  // Commands carried in cmd_i
  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Combine modes; the unused code combines as minimum
  localparam logic [1:0] MODE_MIN = 2'd0;
  localparam logic [1:0] MODE_MAX = 2'd1;
  localparam logic [1:0] MODE_SUM = 2'd2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDENTITY     = 2'd1;

  localparam logic [1:0]       MODE_RESET     = MODE_MIN;
  localparam logic [VAL_W-1:0] IDENTITY_RESET = 64'd2147483647;

  function automatic logic [VAL_W-1:0] seg_join(input logic [1:0] mode,
                                                input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
    logic less;
    begin
      less = $signed(a) < $signed(b);
      case (mode)
        MODE_SUM: seg_join = a + b;
        MODE_MAX: seg_join = less ? b : a;
        default:  seg_join = less ? a : b;
      endcase
    end
  endfunction

endpackage

// ----- hw/rtl/segment_tree_range_query_top.sv -----
// Segment tree over LEAVES leaves (padded to P = 2**ceil(log2(LEAVES))), its 2*P-1 nodes of
// 64 bits held in one memory with a write port and two registered read ports. Register 0
// selects the combine (0 signed minimum, 1 signed maximum, 2 wrapping sum, 3 minimum) and
// register 1 the identity value. After reset and after every write to either register the
// block sweeps the memory with the identity, one node a cycle; no word is taken during the
// sweep. A set or add walks from the leaf to the root, one node write a cycle. A query
// climbs the levels bottom up, reading both boundary nodes of a level in the same cycle
// through the two read ports, and then drains a two-stage combine pipe. One word is worked
// on at a time. The result sits in an output register, so the next word is taken while a
// result still waits downstream.
module segment_tree_range_query_top
  import segtree_pkg::*;
#(
  parameter int LEAVES = DEF_LEAVES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic [$clog2(LEAVES)-1:0]     position_i,
  input  logic signed [VAL_W-1:0]       value_i,
  input  logic [$clog2(LEAVES)-1:0]     range_start_i,
  input  logic [$clog2(LEAVES + 1)-1:0] range_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VAL_W-1:0]       query_result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [VAL_W-1:0]              cfg_data_i
);

  localparam int LVL   = $clog2(LEAVES);
  localparam int P     = 1 << LVL;
  localparam int NODES = 2 * P - 1;
  localparam int NW    = LVL + 1;
  localparam int LW    = $clog2(LVL + 1);

  localparam logic [31:0]    LEAVES_W  = 32'(LEAVES);
  localparam logic [NW-1:0]  LAST_NODE = NW'(NODES - 1);
  localparam logic [LW-1:0]  TOP_LVL   = LW'(LVL);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_CLR  = 8'b0000_0010,
    ST_LEAF = 8'b0000_0100,
    ST_UP   = 8'b0000_1000,
    ST_QRY  = 8'b0001_0000,
    ST_QD1  = 8'b0010_0000,
    ST_QD2  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]       mode_q, mode_d;
  logic [VAL_W-1:0] ident_q, ident_d;
  logic [NW-1:0]    clr_q, clr_d;

  logic [NW-1:0]    node_q, node_d;
  logic [VAL_W-1:0] cur_q, cur_d;
  logic [VAL_W-1:0] val_q;
  logic             add_q, add_d;

  logic [NW-1:0]    l_q, l_d, r_q, r_d, fa_q, fa_d, cb_q, cb_d, base_q, base_d;
  logic [LW-1:0]    lvl_q, lvl_d;
  logic [VAL_W-1:0] ids_q, ids_d;
  logic             kseen_q, kseen_d;
  logic             empty_q, empty_d;
  logic             rdv_a_q, rdv_a_d, rdv_b_q, rdv_b_d;
  logic [VAL_W-1:0] pair_q, pair_d;
  logic             pair_vld_q, pair_vld_d;
  logic [VAL_W-1:0] acc_q, acc_d;
  logic             acc_vld_q, acc_vld_d;

  logic [VAL_W-1:0] out_q;
  logic             out_vld_q;
  logic             out_load;

  // Node memory
  logic [VAL_W-1:0] mem_q [NODES];
  logic [VAL_W-1:0] rd_a_q, rd_b_q;
  logic             mem_we;
  logic [NW-1:0]    mem_waddr, rd_addr_a, rd_addr_b;
  logic [VAL_W-1:0] mem_wdata;

  logic             in_accept;
  logic             cfg_hit;
  logic [31:0]      leaf_ext, start_ext, end_ext, end_cl;
  logic             pos_ok, q_empty;
  logic [NW-1:0]    parent, node_sib, parent_sib;
  logic             take_l, take_r;
  logic [NW-1:0]    qaddr_a, qaddr_b;
  logic [NW:0]      l_inc, cb_inc;
  logic             hit_l, hit_r;
  logic [VAL_W-1:0] ids_add;
  logic [VAL_W-1:0] upd_new, up_val;
  logic [VAL_W-1:0] fin_sum, fin_mm, result;

  assign in_stall_o     = (state_q != ST_IDLE);
  assign in_accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o    = 1'b1;
  assign cfg_hit        = cfg_valid_i &&
                          ((cfg_index_i == REG_COMBINE_MODE) || (cfg_index_i == REG_IDENTITY));
  assign out_valid_o    = out_vld_q;
  assign query_result_o = out_q;

  assign leaf_ext  = 32'(P - 1) + 32'(position_i);
  assign pos_ok    = 32'(position_i) < LEAVES_W;
  assign start_ext = 32'(range_start_i);
  assign end_ext   = 32'(range_end_i);
  assign end_cl    = (end_ext > LEAVES_W) ? LEAVES_W : end_ext;
  assign q_empty   = start_ext >= end_cl;

  assign parent     = (node_q - NW'(1)) >> 1;
  assign node_sib   = node_q[0] ? node_q + NW'(1) : node_q - NW'(1);
  assign parent_sib = parent[0] ? parent + NW'(1) : parent - NW'(1);

  // Boundary nodes of the current level that lie fully inside the range
  assign take_l  = l_q[0] && (l_q < r_q);
  assign take_r  = r_q[0] && (l_q < r_q);
  assign qaddr_a = base_q + l_q - NW'(1);
  assign qaddr_b = base_q + r_q - NW'(2);
  assign l_inc   = {1'b0, l_q} + (NW + 1)'(1);
  assign cb_inc  = {1'b0, cb_q} + (NW + 1)'(1);

  // Children of partial nodes that fall outside the range each fold in one identity
  assign hit_l = (lvl_q != TOP_LVL) && fa_q[0];
  assign hit_r = (lvl_q != TOP_LVL) && cb_q[0];

  always_comb begin
    case ({hit_l, hit_r})
      2'b11:        ids_add = ident_q << 1;
      2'b01, 2'b10: ids_add = ident_q;
      default:      ids_add = '0;
    endcase
  end

  assign upd_new = add_q ? rd_a_q + val_q : val_q;
  assign up_val  = node_q[0] ? seg_join(mode_q, cur_q, rd_a_q) : seg_join(mode_q, rd_a_q, cur_q);

  assign fin_sum = (acc_vld_q ? acc_q : '0) + ids_q;
  assign fin_mm  = !acc_vld_q ? ident_q :
                   (kseen_q ? seg_join(mode_q, acc_q, ident_q) : acc_q);
  assign result  = empty_q ? ident_q : ((mode_q == MODE_SUM) ? fin_sum : fin_mm);

  // Combine pipe: pair the two reads of a level, then fold the pair into the accumulator
  always_comb begin
    pair_vld_d = rdv_a_q || rdv_b_q;
    if (rdv_a_q && rdv_b_q) begin
      pair_d = seg_join(mode_q, rd_a_q, rd_b_q);
    end else if (rdv_a_q) begin
      pair_d = rd_a_q;
    end else begin
      pair_d = rd_b_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    ident_d   = ident_q;
    clr_d     = clr_q;
    node_d    = node_q;
    cur_d     = cur_q;
    add_d     = add_q;
    l_d       = l_q;
    r_d       = r_q;
    fa_d      = fa_q;
    cb_d      = cb_q;
    base_d    = base_q;
    lvl_d     = lvl_q;
    ids_d     = ids_q;
    kseen_d   = kseen_q;
    empty_d   = empty_q;
    rdv_a_d   = 1'b0;
    rdv_b_d   = 1'b0;
    acc_d     = acc_q;
    acc_vld_d = acc_vld_q;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = ident_q;
    rd_addr_a = leaf_ext[NW-1:0];
    rd_addr_b = qaddr_b;

    if (pair_vld_q) begin
      acc_d     = acc_vld_q ? seg_join(mode_q, acc_q, pair_q) : pair_q;
      acc_vld_d = 1'b1;
    end

    unique case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = ident_q;
        if (clr_q == LAST_NODE) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + NW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_i) inside
            CMD_SET, CMD_ADD: begin
              // leaf read is issued now from the port address
              if (pos_ok) begin
                node_d  = leaf_ext[NW-1:0];
                add_d   = (cmd_i == CMD_ADD);
                state_d = ST_LEAF;
              end
            end
            CMD_QUERY: begin
              empty_d = q_empty;
              if (q_empty) begin
                state_d = ST_FIN;
              end else begin
                l_d       = start_ext[NW-1:0];
                fa_d      = start_ext[NW-1:0];
                r_d       = end_cl[NW-1:0];
                cb_d      = end_cl[NW-1:0];
                base_d    = NW'(P);
                lvl_d     = '0;
                ids_d     = '0;
                kseen_d   = 1'b0;
                acc_vld_d = 1'b0;
                state_d   = ST_QRY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LEAF: begin
        mem_we    = 1'b1;
        mem_waddr = node_q;
        mem_wdata = upd_new;
        cur_d     = upd_new;
        rd_addr_a = node_sib;
        state_d   = ST_UP;
      end
      ST_UP: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_val;
        cur_d     = up_val;
        node_d    = parent;
        rd_addr_a = parent_sib;
        if (parent == '0) begin
          state_d = ST_IDLE;
        end
      end
      ST_QRY: begin
        rd_addr_a = qaddr_a;
        rd_addr_b = qaddr_b;
        rdv_a_d   = take_l;
        rdv_b_d   = take_r;
        ids_d     = ids_q + ids_add;
        kseen_d   = kseen_q || hit_l || hit_r;
        l_d       = l_inc[NW:1];
        r_d       = r_q >> 1;
        fa_d      = fa_q >> 1;
        cb_d      = cb_inc[NW:1];
        base_d    = base_q >> 1;
        if (lvl_q == TOP_LVL) begin
          state_d = ST_QD1;
        end else begin
          lvl_d = lvl_q + LW'(1);
        end
      end
      ST_QD1: state_d = ST_QD2;
      ST_QD2: state_d = ST_FIN;
      ST_FIN: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // register write refills the tree with the identity
    if (cfg_valid_i && (cfg_index_i == REG_COMBINE_MODE)) begin
      mode_d = cfg_data_i[1:0];
    end
    if (cfg_valid_i && (cfg_index_i == REG_IDENTITY)) begin
      ident_d = cfg_data_i;
    end
    if (cfg_hit) begin
      state_d = ST_CLR;
      clr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      mode_q     <= MODE_RESET;
      ident_q    <= IDENTITY_RESET;
      clr_q      <= '0;
      node_q     <= '0;
      add_q      <= 1'b0;
      l_q        <= '0;
      r_q        <= '0;
      fa_q       <= '0;
      cb_q       <= '0;
      base_q     <= '0;
      lvl_q      <= '0;
      kseen_q    <= 1'b0;
      empty_q    <= 1'b0;
      rdv_a_q    <= 1'b0;
      rdv_b_q    <= 1'b0;
      pair_vld_q <= 1'b0;
      acc_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      ident_q    <= ident_d;
      clr_q      <= clr_d;
      node_q     <= node_d;
      add_q      <= add_d;
      l_q        <= l_d;
      r_q        <= r_d;
      fa_q       <= fa_d;
      cb_q       <= cb_d;
      base_q     <= base_d;
      lvl_q      <= lvl_d;
      kseen_q    <= kseen_d;
      empty_q    <= empty_d;
      rdv_a_q    <= rdv_a_d;
      rdv_b_q    <= rdv_b_d;
      pair_vld_q <= pair_vld_d;
      acc_vld_q  <= acc_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    ids_q  <= ids_d;
    pair_q <= pair_d;
    acc_q  <= acc_d;
    if (in_accept) begin
      val_q <= value_i;
    end
    if (out_load) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= mem_q[rd_addr_a];
    rd_b_q <= mem_q[rd_addr_b];
  end

  a_qry_addr_in_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QRY) |-> ((!take_l || (qaddr_a <= LAST_NODE)) &&
                             (!take_r || (qaddr_b <= LAST_NODE))))
    else $error("query walk reads past the last node");

  a_up_below_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UP) |-> (node_q != '0))
    else $error("update walk continued above the root");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_FIN))
    else $error("result shown without finishing a query");

  a_clear_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> (clr_q <= LAST_NODE))
    else $error("clearing pass ran past the last node");

endmodule
